>>> design/msfc_pkg.sv
// Shared types, coefficients and helpers for the motor speed filter and controller.
// No dependencies; every other design file imports this package.
package msfc_pkg;

    // Input and result words.
    typedef struct packed {
        logic signed [31:0] encoder_count;
        logic               restart;
    } in_word_t;

    typedef struct packed {
        logic signed [7:0]  drive_power;
        logic signed [31:0] filtered_speed;
        logic               clamped;
    } out_word_t;

    // Unsigned Q7.24 coefficients.
    localparam logic [30:0] K_SPEED = 31'd905761;
    localparam logic [30:0] K_POLE  = 31'd16258253;
    localparam logic [30:0] K_CE    = 31'd543485682;
    localparam logic [30:0] K_CE1   = 31'd1033948365;
    localparam logic [30:0] K_CE2   = 31'd491755920;
    localparam logic [30:0] K_CY1   = 31'd27962027;
    localparam logic [30:0] K_CY2   = 31'd11184811;

    localparam logic signed [23:0] POWER_LIMIT = 24'sd100;

    // Accumulator width of the shared multiplier and width of its rounded result.
    localparam int ACC_W = 72;
    localparam int RES_W = 48;

    // Register index of the configuration port.
    localparam logic REG_TARGET_SPEED = 1'b0;

    // Where a finished product goes.
    typedef enum logic [1:0] {
        DST_RAW  = 2'd0,
        DST_FILT = 2'd1,
        DST_PW   = 2'd2
    } mul_dst_t;

    // Control that travels with one multiplier pass.
    typedef struct packed {
        logic     first;
        logic     last;
        logic     shift16;
        logic     neg;
        mul_dst_t dst;
    } mul_tag_t;

    // Rounded product handed back to the sequencer.
    typedef struct packed {
        logic                    done;
        logic                    neg;
        mul_dst_t                dst;
        logic signed [RES_W-1:0] value;
    } mul_res_t;

    function automatic logic signed [31:0] sat32(input logic signed [RES_W-1:0] x);
        logic signed [31:0] r;
        if (x > $signed({{(RES_W-32){1'b0}}, 32'h7FFF_FFFF})) begin
            r = 32'sh7FFF_FFFF;
        end else if (x < $signed({{(RES_W-32){1'b1}}, 32'h8000_0000})) begin
            r = 32'sh8000_0000;
        end else begin
            r = x[31:0];
        end
        return r;
    endfunction

    function automatic logic signed [39:0] sat40(input logic signed [RES_W-1:0] x);
        logic signed [39:0] r;
        if (x > $signed({{(RES_W-40){1'b0}}, 40'h7F_FFFF_FFFF})) begin
            r = 40'sh7F_FFFF_FFFF;
        end else if (x < $signed({{(RES_W-40){1'b1}}, 40'h80_0000_0000})) begin
            r = 40'sh80_0000_0000;
        end else begin
            r = x[39:0];
        end
        return r;
    endfunction

endpackage

>>> design/msfc_cfg.sv
// APB-style configuration register holding the reference speed.
// Depends on msfc_pkg for the register index.
module msfc_cfg import msfc_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    output logic signed [21:0] target_speed
);

    logic signed [21:0] target_reg;
    logic               wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite & pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            target_reg <= '0;
        end else if (wr_en && paddr[2] == REG_TARGET_SPEED) begin
            target_reg <= pwdata[21:0];
        end
    end

    always_comb begin
        if (paddr[2] == REG_TARGET_SPEED) begin
            prdata = {{10{target_reg[21]}}, target_reg};
        end else begin
            prdata = '0;
        end
    end

    assign target_speed = target_reg;

endmodule

>>> design/msfc_mul.sv
// Shared multiply-accumulate unit: one 33x32 product per cycle, accumulated over
// one or two passes and rounded half up to a signed Q32.16 result. Depends on msfc_pkg.
module msfc_mul import msfc_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               op_valid,
    input  logic signed [32:0] op_a,
    input  logic [30:0]        op_c,
    input  mul_tag_t           op_tag,
    output mul_res_t           res
);

    localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(1) <<< 23;

    logic signed [64:0]      prod_full;
    logic signed [63:0]      prod_reg;
    logic                    vld1_reg;
    mul_tag_t                tag1_reg;
    logic signed [ACC_W-1:0] acc_reg;
    logic signed [ACC_W-1:0] addend;
    logic signed [ACC_W-1:0] base;
    logic                    done_reg;
    logic                    neg_reg;
    mul_dst_t                dst_reg;

    assign prod_full = op_a * $signed({1'b0, op_c});

    always_comb begin
        addend = {{(ACC_W-64){prod_reg[63]}}, prod_reg};
        if (tag1_reg.shift16) begin
            addend = addend <<< 16;
        end
        // The rounding half is preloaded when a new product starts.
        base = tag1_reg.first ? ROUND_HALF : acc_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld1_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            vld1_reg <= op_valid;
            done_reg <= vld1_reg & tag1_reg.last;
        end
        prod_reg <= prod_full[63:0];
        tag1_reg <= op_tag;
        if (vld1_reg) begin
            acc_reg <= base + addend;
            neg_reg <= tag1_reg.neg;
            dst_reg <= tag1_reg.dst;
        end
    end

    assign res.done  = done_reg;
    assign res.neg   = neg_reg;
    assign res.dst   = dst_reg;
    assign res.value = acc_reg[ACC_W-1:ACC_W-RES_W];

endmodule

>>> design/motor_speed_filter_and_controller_core.sv
// Motor speed filter and speed controller core.
// A new word is accepted only in the idle state, when s_ready is high, and runs through nine
// multiplier issue steps, the two-stage multiplier pipeline and the saturate and format steps.
// No new word is taken before the current one is finished; a result still waiting for m_ready
// holds the next word at its last step.
// Reset (aresetn, synchronous, active low) clears all history and the reference speed.
module motor_speed_filter_and_controller_core import msfc_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  in_word_t    s_data,
    output logic        m_valid,
    input  logic        m_ready,
    output out_word_t   m_data,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } state_t;

    localparam logic [3:0] STEP_FILT   = 4'd4;
    localparam logic [3:0] STEP_ERR    = 4'd5;
    localparam logic [3:0] STEP_PW     = 4'd11;
    localparam logic [3:0] STEP_FINISH = 4'd12;

    state_t             state_reg;
    logic [3:0]         step_reg;
    logic signed [21:0] target_speed;

    // History.
    logic signed [31:0] last_count_reg;
    logic signed [31:0] last_raw_reg;
    logic signed [31:0] last_filt_reg;
    logic signed [31:0] last_err_reg;
    logic signed [31:0] older_err_reg;
    logic signed [39:0] last_pw_reg;
    logic signed [39:0] older_pw_reg;

    // Working values of the current word.
    logic signed [31:0]      count_reg;
    logic signed [31:0]      diff_reg;
    logic signed [31:0]      raw_reg;
    logic signed [RES_W-1:0] filt_sum_reg;
    logic signed [31:0]      filt_reg;
    logic signed [31:0]      err_reg;
    logic signed [RES_W-1:0] pw_sum_reg;
    logic signed [39:0]      pw_reg;

    logic                    m_valid_reg;
    out_word_t               m_data_reg;

    logic                    op_valid;
    logic signed [32:0]      op_a;
    logic [30:0]             op_c;
    mul_tag_t                op_tag;
    mul_res_t                res;

    logic signed [31:0]      raw_sat;
    logic signed [33:0]      err_wide;
    logic signed [23:0]      pw_floor;
    logic signed [23:0]      pw_whole;
    logic signed [7:0]       drive;
    logic                    lim;
    logic                    finish;

    msfc_cfg u_cfg (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .target_speed (target_speed)
    );

    msfc_mul u_mul (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .op_valid (op_valid),
        .op_a     (op_a),
        .op_c     (op_c),
        .op_tag   (op_tag),
        .res      (res)
    );

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // Multiplier schedule. Forty-bit powers take a low and a high pass; the error
    // product goes last because it waits for the filtered speed.
    always_comb begin
        op_valid = (state_reg == ST_RUN);
        op_a     = '0;
        op_c     = '0;
        op_tag   = '{first: 1'b1, last: 1'b1, shift16: 1'b0, neg: 1'b0, dst: DST_PW};
        case (step_reg)
            4'd0: begin
                op_a           = {diff_reg[31], diff_reg};
                op_c           = K_SPEED;
                op_tag.shift16 = 1'b1;
                op_tag.dst     = DST_RAW;
            end
            4'd1: begin
                op_a       = {last_filt_reg[31], last_filt_reg};
                op_c       = K_POLE;
                op_tag.dst = DST_FILT;
            end
            4'd2: begin
                op_a        = {17'd0, last_pw_reg[15:0]};
                op_c        = K_CY1;
                op_tag.last = 1'b0;
            end
            4'd3: begin
                op_a           = {{9{last_pw_reg[39]}}, last_pw_reg[39:16]};
                op_c           = K_CY1;
                op_tag.first   = 1'b0;
                op_tag.shift16 = 1'b1;
            end
            4'd4: begin
                op_a        = {17'd0, older_pw_reg[15:0]};
                op_c        = K_CY2;
                op_tag.last = 1'b0;
            end
            4'd5: begin
                op_a           = {{9{older_pw_reg[39]}}, older_pw_reg[39:16]};
                op_c           = K_CY2;
                op_tag.first   = 1'b0;
                op_tag.shift16 = 1'b1;
                op_tag.neg     = 1'b1;
            end
            4'd6: begin
                op_a       = {last_err_reg[31], last_err_reg};
                op_c       = K_CE1;
                op_tag.neg = 1'b1;
            end
            4'd7: begin
                op_a = {older_err_reg[31], older_err_reg};
                op_c = K_CE2;
            end
            4'd8: begin
                op_a = {err_reg[31], err_reg};
                op_c = K_CE;
            end
            default: begin
                op_valid = 1'b0;
            end
        endcase
    end

    // Result formatting: saturate the raw speed, form the speed error, truncate the Q24.16 power toward zero and clamp.
    always_comb begin
        raw_sat  = sat32(res.value);
        err_wide = {{12{target_speed[21]}}, target_speed} - {{2{filt_reg[31]}}, filt_reg};
        pw_floor = pw_reg[39:16];
        if (pw_reg[39] && pw_reg[15:0] != 16'd0) begin
            pw_whole = pw_floor + 24'sd1;
        end else begin
            pw_whole = pw_floor;
        end
        lim = 1'b0;
        if (pw_whole > POWER_LIMIT) begin
            drive = POWER_LIMIT[7:0];
            lim   = 1'b1;
        end else if (pw_whole < -POWER_LIMIT) begin
            drive = 8'(-POWER_LIMIT);
            lim   = 1'b1;
        end else begin
            drive = pw_whole[7:0];
        end
        finish = (state_reg == ST_RUN) && (step_reg == STEP_FINISH)
                 && (!m_valid_reg || m_ready);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            step_reg       <= '0;
            m_valid_reg    <= 1'b0;
            last_count_reg <= '0;
            last_raw_reg   <= '0;
            last_filt_reg  <= '0;
            last_err_reg   <= '0;
            older_err_reg  <= '0;
            last_pw_reg    <= '0;
            older_pw_reg   <= '0;
        end else begin
            if (m_valid_reg && m_ready && !finish) begin
                m_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        state_reg    <= ST_RUN;
                        step_reg     <= '0;
                        count_reg    <= s_data.encoder_count;
                        pw_sum_reg   <= '0;
                        if (s_data.restart) begin
                            last_count_reg <= '0;
                            last_raw_reg   <= '0;
                            last_filt_reg  <= '0;
                            last_err_reg   <= '0;
                            older_err_reg  <= '0;
                            last_pw_reg    <= '0;
                            older_pw_reg   <= '0;
                            diff_reg       <= s_data.encoder_count;
                            filt_sum_reg   <= '0;
                        end else begin
                            diff_reg     <= s_data.encoder_count - last_count_reg;
                            filt_sum_reg <= {{(RES_W-32){last_raw_reg[31]}}, last_raw_reg};
                        end
                    end
                end
                ST_RUN: begin
                    if (step_reg != STEP_FINISH) begin
                        step_reg <= step_reg + 4'd1;
                    end
                    if (step_reg == STEP_FILT) begin
                        filt_reg <= sat32(filt_sum_reg);
                    end
                    if (step_reg == STEP_ERR) begin
                        err_reg <= sat32({{(RES_W-34){err_wide[33]}}, err_wide});
                    end
                    if (step_reg == STEP_PW) begin
                        pw_reg <= sat40(pw_sum_reg);
                    end
                    if (finish) begin
                        state_reg                 <= ST_IDLE;
                        m_valid_reg               <= 1'b1;
                        m_data_reg.drive_power    <= drive;
                        m_data_reg.filtered_speed <= filt_reg;
                        m_data_reg.clamped        <= lim;
                        older_pw_reg              <= last_pw_reg;
                        last_pw_reg               <= pw_reg;
                        older_err_reg             <= last_err_reg;
                        last_err_reg              <= err_reg;
                        last_raw_reg              <= raw_reg;
                        last_filt_reg             <= filt_reg;
                        last_count_reg            <= count_reg;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase

            // Fold finished products into the filter and power sums.
            if (res.done) begin
                case (res.dst)
                    DST_RAW: begin
                        raw_reg      <= raw_sat;
                        filt_sum_reg <= filt_sum_reg + {{(RES_W-32){raw_sat[31]}}, raw_sat};
                    end
                    DST_FILT: begin
                        filt_sum_reg <= filt_sum_reg + res.value;
                    end
                    DST_PW: begin
                        if (res.neg) begin
                            pw_sum_reg <= pw_sum_reg - res.value;
                        end else begin
                            pw_sum_reg <= pw_sum_reg + res.value;
                        end
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

endmodule
